// ===== sv/ndefp_pkg.sv =====
// Shared types, constants and helpers for the NDEF message parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package ndefp_pkg;

  localparam int LEN_W = 32;

  // NDEF header flag bits
  localparam logic [7:0] FLAG_MB  = 8'h80;
  localparam logic [7:0] FLAG_ME  = 8'h40;
  localparam logic [7:0] FLAG_CF  = 8'h20;
  localparam logic [7:0] FLAG_SR  = 8'h10;
  localparam logic [7:0] FLAG_IL  = 8'h08;
  localparam logic [2:0] TNF_MASK = 3'h7;
  localparam logic [2:0] TNF_UNCHANGED = 3'h6;

  typedef enum logic [2:0] {
    SEC_FLAGS   = 3'd0,
    SEC_TLEN    = 3'd1,
    SEC_PLEN    = 3'd2,
    SEC_ILEN    = 3'd3,
    SEC_TYPE    = 3'd4,
    SEC_ID      = 3'd5,
    SEC_PAYLOAD = 3'd6,
    SEC_IGNORED = 3'd7
  } section_t;

  typedef enum logic [3:0] {
    ST_BUSY             = 4'd0,
    ST_ACCEPTED         = 4'd1,
    ST_BEGIN_REPEATED   = 4'd2,
    ST_BEGIN_MISSING    = 4'd3,
    ST_END_REPEATED     = 4'd4,
    ST_BAD_CHUNK_FORMAT = 4'd5,
    ST_HEADER_CUT       = 4'd6,
    ST_CHUNK_TYPE       = 4'd7,
    ST_CONTENT_CUT      = 4'd8,
    ST_CHUNK_ID         = 4'd9,
    ST_END_MISSING      = 4'd10
  } status_t;

  typedef struct packed {
    section_t         phase;
    logic             seen_begin;
    logic             seen_end;
    logic             stopped;
    status_t          error_code;
    logic [7:0]       header_flags;
    logic [7:0]       type_len;
    logic [7:0]       id_length;
    logic [LEN_W-1:0] payload_length;
    logic [LEN_W-1:0] bytes_left;
    logic             chunk_has_data;
    logic [2:0]       held_format;
  } parse_state_t;

  typedef struct packed {
    logic [7:0] byte_value;
    section_t   section;
    logic [2:0] record_format;
    logic       record_end;
    status_t    status;
  } result_t;

  // First content section after 'after' with nonzero length; SEC_FLAGS if none.
  function automatic section_t next_section(input section_t after,
                                            input logic [7:0] tlen,
                                            input logic [7:0] ilen,
                                            input logic [LEN_W-1:0] plen);
    section_t r;
    r = SEC_FLAGS;
    if (after < SEC_TYPE && tlen != 8'd0) r = SEC_TYPE;
    else if (after < SEC_ID && ilen != 8'd0) r = SEC_ID;
    else if (after < SEC_PAYLOAD && plen != '0) r = SEC_PAYLOAD;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ndefp_step.sv =====
// One parse step: classifies a byte and computes the next parser state.
// Depends on ndefp_pkg.
`default_nettype none

module ndefp_step
  import ndefp_pkg::*;
(
  input  parse_state_t st_cur,
  input  logic [7:0]   data_byte,
  input  logic         end_of_input,
  output parse_state_t st_next,
  output result_t      res
);

  parse_state_t ns;
  status_t      stat;
  section_t     nxt;
  logic         unit_done;
  logic         header_done;
  logic         tnf6;
  logic         il;
  logic         mb;
  logic         me;
  logic [2:0]   tnf_in;
  logic [2:0]   cnt3;
  logic [2:0]   fmt;
  logic [LEN_W-1:0] bl_dec;

  always_comb begin
    ns          = st_cur;
    stat        = ST_BUSY;
    nxt         = SEC_FLAGS;
    unit_done   = 1'b0;
    header_done = 1'b0;
    mb          = (data_byte & FLAG_MB) != 8'd0;
    me          = (data_byte & FLAG_ME) != 8'd0;
    tnf_in      = data_byte[2:0] & TNF_MASK;
    cnt3        = st_cur.bytes_left[2:0] - 3'd1;
    bl_dec      = st_cur.bytes_left - LEN_W'(1);
    fmt         = 3'd0;
    res.byte_value    = data_byte;
    res.section       = SEC_IGNORED;
    res.record_format = 3'd0;
    res.record_end    = 1'b0;
    res.status        = st_cur.error_code;

    if (!st_cur.stopped) begin
      // flags byte
      if (st_cur.phase == SEC_FLAGS) begin
        ns.header_flags = data_byte;
        if (mb && st_cur.seen_begin) stat = ST_BEGIN_REPEATED;
        else if (!mb && !st_cur.seen_begin) stat = ST_BEGIN_MISSING;
        else if (me && st_cur.seen_end) stat = ST_END_REPEATED;
        else begin
          ns.seen_begin = 1'b1;
          if (me) ns.seen_end = 1'b1;
          if (tnf_in != TNF_UNCHANGED && st_cur.chunk_has_data) stat = ST_BAD_CHUNK_FORMAT;
          else if (end_of_input) stat = ST_HEADER_CUT;
          else begin
            if (tnf_in != TNF_UNCHANGED) ns.held_format = tnf_in;
            ns.phase = SEC_TLEN;
          end
        end
      end

      tnf6 = (ns.header_flags[2:0] & TNF_MASK) == TNF_UNCHANGED;
      il   = (ns.header_flags & FLAG_IL) != 8'd0;

      unique case (st_cur.phase) inside
        SEC_TLEN: begin
          ns.type_len = data_byte;
          if (end_of_input) stat = ST_HEADER_CUT;
          else if (tnf6 && data_byte != 8'd0) stat = ST_CHUNK_TYPE;
          else begin
            ns.phase          = SEC_PLEN;
            ns.bytes_left     = ((ns.header_flags & FLAG_SR) != 8'd0) ? LEN_W'(1) : LEN_W'(4);
            ns.payload_length = '0;
            ns.id_length      = 8'd0;
          end
        end
        SEC_PLEN: begin
          ns.payload_length = {st_cur.payload_length[LEN_W-9:0], data_byte};
          ns.bytes_left     = LEN_W'(cnt3);
          if (cnt3 != 3'd0 || il) begin
            if (end_of_input) stat = ST_HEADER_CUT;
            else if (cnt3 == 3'd0) ns.phase = SEC_ILEN;
          end else begin
            header_done = 1'b1;
          end
        end
        SEC_ILEN: begin
          ns.id_length = data_byte;
          header_done  = 1'b1;
        end
        SEC_TYPE, SEC_ID, SEC_PAYLOAD: begin
          ns.bytes_left = bl_dec;
          if (bl_dec == '0) begin
            nxt = next_section(st_cur.phase, ns.type_len, ns.id_length,
                               ns.payload_length);
            if (nxt == SEC_FLAGS) unit_done = 1'b1;
            else if (end_of_input) stat = ST_CONTENT_CUT;
            else ns.phase = nxt;
          end else if (end_of_input) begin
            stat = ST_CONTENT_CUT;
          end
        end
        default: begin
        end
      endcase

      if (header_done) begin
        nxt = next_section(SEC_ILEN, ns.type_len, ns.id_length, ns.payload_length);
        if (nxt != SEC_FLAGS && end_of_input) stat = ST_CONTENT_CUT;
        else if (tnf6 && il) stat = ST_CHUNK_ID;
        else if (nxt != SEC_FLAGS) ns.phase = nxt;
        else unit_done = 1'b1;
      end

      // load the byte counter for a newly entered content section
      if (ns.phase != st_cur.phase) begin
        unique case (ns.phase) inside
          SEC_TYPE:    ns.bytes_left = LEN_W'(ns.type_len);
          SEC_ID:      ns.bytes_left = LEN_W'(ns.id_length);
          SEC_PAYLOAD: ns.bytes_left = ns.payload_length;
          default: begin
          end
        endcase
      end

      fmt = ns.held_format;
      if (unit_done) begin
        ns.phase = SEC_FLAGS;
        if ((ns.header_flags & FLAG_CF) != 8'd0) begin
          ns.chunk_has_data = 1'b1;
          if (end_of_input) stat = ST_END_MISSING;
        end else begin
          res.record_end    = 1'b1;
          ns.chunk_has_data = 1'b0;
          ns.held_format    = 3'd0;
          if (ns.seen_end) stat = ST_ACCEPTED;
          else if (end_of_input) stat = ST_END_MISSING;
        end
      end

      if (stat != ST_BUSY) begin
        ns.error_code = stat;
        ns.stopped    = 1'b1;
      end

      res.section       = st_cur.phase;
      res.record_format = fmt;
      res.status        = stat;
    end else begin
      tnf6 = 1'b0;
      il   = 1'b0;
    end
    st_next = ns;
  end

endmodule

`default_nettype wire

// ===== sv/ndef_message_parser.sv =====
// Each byte passes through the input register, ndefp_step and the result register.
// Throughput: one byte per cycle; the input register and the result register
// let a new byte enter every cycle while out_ready holds high.
// Work per byte: one pass through ndefp_step (32-bit length shift/decrement and compare).
// Reset (rst, synchronous, active high): empties both registers and returns the parser
// to the start of a new message. Depends on ndefp_pkg and ndefp_step.
`default_nettype none

module ndef_message_parser
  import ndefp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_input,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      byte_value,
  output logic [2:0]      section,
  output logic [2:0]      record_format,
  output logic            record_end,
  output logic [3:0]      status
);

  // input register
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_eoi;

  // parser state and result register
  parse_state_t st;
  parse_state_t st_next;
  result_t      step_res;
  result_t      out_res;

  logic advance;
  logic in_take;

  // A byte moves into the parser when the result slot is free or being drained.
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;
  assign in_take  = in_valid && in_ready;

  ndefp_step u_step (
    .st_cur       (st),
    .data_byte    (in_byte),
    .end_of_input (in_eoi),
    .st_next      (st_next),
    .res          (step_res)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
      st        <= '0;
    end else begin
      in_full   <= in_take || (in_full && !advance);
      out_valid <= advance || (out_valid && !out_ready);
      if (advance) st <= st_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte <= data_byte;
      in_eoi  <= end_of_input;
    end
    if (advance) out_res <= step_res;
  end

  assign byte_value    = out_res.byte_value;
  assign section       = out_res.section;
  assign record_format = out_res.record_format;
  assign record_end    = out_res.record_end;
  assign status        = out_res.status;

endmodule

`default_nettype wire

// ===== sv/ndefp_checker.sv =====
// Port-level checks for ndef_message_parser, attached by bind.
// Depends on ndefp_pkg and the top level's ports.
`default_nettype none

module ndefp_checker
  import ndefp_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] byte_value,
  input wire logic [2:0] section,
  input wire logic [2:0] record_format,
  input wire logic       record_end,
  input wire logic [3:0] status
);

  // set once a final status has been delivered
  logic done;
  logic [3:0] final_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      done         <= 1'b0;
      final_status <= 4'd0;
    end else if (out_valid && out_ready && !done && status != ST_BUSY) begin
      done         <= 1'b1;
      final_status <= status;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_value) && $stable(status))
    else $error("result changed while stalled");

  a_after_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && done |-> section == SEC_IGNORED && !record_end && record_format == 3'd0
                          && status == final_status)
    else $error("byte after final status not ignored");

  a_rend_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_end |->
      status == ST_BUSY || status == ST_ACCEPTED || status == ST_END_MISSING)
    else $error("record end with unexpected status");

  a_ignored_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && section == SEC_IGNORED |-> status != ST_BUSY)
    else $error("ignored byte while still parsing");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present right after reset");

endmodule

bind ndef_message_parser ndefp_checker u_ndefp_checker (.*);

`default_nettype wire

// ===== verif/ndef_message_parser_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for ndef_message_parser: watches both channels, tracks the parse state
// and compares every result with its prediction. Depends on ndefp_pkg.
module ndef_message_parser_checker
  import ndefp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_input,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic [7:0] byte_value,
  input  wire logic [2:0] section,
  input  wire logic [2:0] record_format,
  input  wire logic       record_end,
  input  wire logic [3:0] status,
  output int              mismatch_count,
  output int              pending_results
);

  localparam int PRINT_CAP = 100;

  result_t     tagged_q[$];
  int          result_idx;

  // parse state mirror
  section_t    phase;
  logic        begin_seen, end_seen, halted;
  status_t     final_code;
  logic [7:0]  hdr, tlen, ilen;
  logic [31:0] plen, remaining;
  logic        in_chunk;
  logic [2:0]  kept_tnf;

  task automatic clear_parser();
    phase = SEC_FLAGS;
    begin_seen = 1'b0;
    end_seen = 1'b0;
    halted = 1'b0;
    final_code = ST_BUSY;
    hdr = 8'd0;
    tlen = 8'd0;
    ilen = 8'd0;
    plen = 32'd0;
    remaining = 32'd0;
    in_chunk = 1'b0;
    kept_tnf = 3'd0;
  endtask

  // next content section with a nonzero length, SEC_FLAGS when none is left
  function automatic section_t content_after(input section_t after);
    if (after < SEC_TYPE && tlen != 8'd0) return SEC_TYPE;
    if (after < SEC_ID && ilen != 8'd0) return SEC_ID;
    if (after < SEC_PAYLOAD && plen != 32'd0) return SEC_PAYLOAD;
    return SEC_FLAGS;
  endfunction

  task automatic open_section(input section_t s);
    phase = s;
    if (s == SEC_TYPE) remaining = {24'd0, tlen};
    else if (s == SEC_ID) remaining = {24'd0, ilen};
    else remaining = plen;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eoi, output result_t r);
    section_t cur, nxt;
    status_t  st;
    logic     unit_done, hdr_done, tnf6, has_il;
    cur = phase;
    st = ST_BUSY;
    unit_done = 1'b0;
    hdr_done = 1'b0;
    r.byte_value = b;
    r.record_end = 1'b0;
    if (halted) begin
      r.section = SEC_IGNORED;
      r.record_format = 3'd0;
      r.status = final_code;
    end else begin
      if (cur == SEC_FLAGS) begin
        hdr = b;
        if ((b & FLAG_MB) != 8'd0 && begin_seen) st = ST_BEGIN_REPEATED;
        else if ((b & FLAG_MB) == 8'd0 && !begin_seen) st = ST_BEGIN_MISSING;
        else if ((b & FLAG_ME) != 8'd0 && end_seen) st = ST_END_REPEATED;
        else begin
          begin_seen = 1'b1;
          if ((b & FLAG_ME) != 8'd0) end_seen = 1'b1;
          if (b[2:0] != TNF_UNCHANGED && in_chunk) st = ST_BAD_CHUNK_FORMAT;
          else if (eoi) st = ST_HEADER_CUT;
          else begin
            if (b[2:0] != TNF_UNCHANGED) kept_tnf = b[2:0];
            phase = SEC_TLEN;
          end
        end
      end
      tnf6 = (hdr[2:0] == TNF_UNCHANGED);
      has_il = (hdr & FLAG_IL) != 8'd0;
      case (cur)
        SEC_TLEN: begin
          tlen = b;
          if (eoi) st = ST_HEADER_CUT;
          else if (tnf6 && b != 8'd0) st = ST_CHUNK_TYPE;
          else begin
            phase = SEC_PLEN;
            remaining = ((hdr & FLAG_SR) != 8'd0) ? 32'd1 : 32'd4;
            plen = 32'd0;
            ilen = 8'd0;
          end
        end
        SEC_PLEN: begin
          plen = {plen[23:0], b};
          remaining = (remaining - 32'd1) & 32'd7;
          if (remaining != 32'd0 || has_il) begin
            if (eoi) st = ST_HEADER_CUT;
            else if (remaining == 32'd0) phase = SEC_ILEN;
          end else begin
            hdr_done = 1'b1;
          end
        end
        SEC_ILEN: begin
          ilen = b;
          hdr_done = 1'b1;
        end
        SEC_TYPE, SEC_ID, SEC_PAYLOAD: begin
          remaining = remaining - 32'd1;
          if (remaining == 32'd0) begin
            nxt = content_after(cur);
            if (nxt == SEC_FLAGS) unit_done = 1'b1;
            else if (eoi) st = ST_CONTENT_CUT;
            else open_section(nxt);
          end else if (eoi) begin
            st = ST_CONTENT_CUT;
          end
        end
        default: ;
      endcase
      if (hdr_done) begin
        nxt = content_after(SEC_ILEN);
        if (nxt != SEC_FLAGS && eoi) st = ST_CONTENT_CUT;
        else if (tnf6 && has_il) st = ST_CHUNK_ID;
        else if (nxt != SEC_FLAGS) open_section(nxt);
        else unit_done = 1'b1;
      end
      // format shown is the one held before this byte closes the record
      r.record_format = kept_tnf;
      if (unit_done) begin
        phase = SEC_FLAGS;
        if ((hdr & FLAG_CF) != 8'd0) begin
          in_chunk = 1'b1;
          if (eoi) st = ST_END_MISSING;
        end else begin
          r.record_end = 1'b1;
          in_chunk = 1'b0;
          kept_tnf = 3'd0;
          if (end_seen) st = ST_ACCEPTED;
          else if (eoi) st = ST_END_MISSING;
        end
      end
      if (st != ST_BUSY) begin
        final_code = st;
        halted = 1'b1;
      end
      r.section = cur;
      r.status = st;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("[%0t] result %0d %s: got %0d, want %0d", $time, result_idx, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      clear_parser();
      tagged_q.delete();
      result_idx = 0;
    end else begin
      if (in_valid && in_ready) begin
        parse_byte(data_byte, end_of_input, want);
        tagged_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (tagged_q.size() == 0) begin
          report_mismatch("result with no request, byte_value", 32'(byte_value), 32'd0);
        end else begin
          want = tagged_q.pop_front();
          if (byte_value !== want.byte_value)
            report_mismatch("byte_value", 32'(byte_value), 32'(want.byte_value));
          if (section !== want.section)
            report_mismatch("section", 32'(section), 32'(want.section));
          if (record_format !== want.record_format)
            report_mismatch("record_format", 32'(record_format), 32'(want.record_format));
          if (record_end !== want.record_end)
            report_mismatch("record_end", 32'(record_end), 32'(want.record_end));
          if (status !== want.status)
            report_mismatch("status", 32'(status), 32'(want.status));
        end
        result_idx++;
      end
    end
    pending_results <= tagged_q.size();
  end

endmodule

// ===== verif/ndef_message_parser_tb.sv =====
`timescale 1ns / 100ps
// Top of the ndef_message_parser testbench: builds one long NDEF message, drives it
// with random gaps and back-pressure, and gives the verdict from the checker's count.
// Depends on ndefp_pkg, ndef_message_parser and ndef_message_parser_checker.
module ndef_message_parser_tb
  import ndefp_pkg::*;
();

  localparam int CLK_PERIOD       = 4;
  localparam int BODY_BYTES       = 1200;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES     = 20;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       end_of_input;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] byte_value;
  logic [2:0] section;
  logic [2:0] record_format;
  logic       record_end;
  logic [3:0] status;
  int         mismatch_count;
  int         pending_results;

  // one request on the input channel
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } byte_req_t;

  byte_req_t message_q[$];
  bit        chunk_open;       // generator is inside a chunked record
  bit        plan_ready;
  int        accepted_reqs;
  int        hold_mark;        // request count at which the sink holds off once
  bit        long_hold_done;

  always #(CLK_PERIOD / 2) clk = ~clk;

  ndef_message_parser dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .end_of_input(end_of_input),
    .out_valid(out_valid), .out_ready(out_ready),
    .byte_value(byte_value), .section(section), .record_format(record_format),
    .record_end(record_end), .status(status)
  );

  ndef_message_parser_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .end_of_input(end_of_input),
    .out_valid(out_valid), .out_ready(out_ready),
    .byte_value(byte_value), .section(section), .record_format(record_format),
    .record_end(record_end), .status(status),
    .mismatch_count(mismatch_count), .pending_results(pending_results)
  );

  // Gap length: mostly none or short, now and then a long one. Calm means no gap.
  function automatic int pick_pause(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Field lengths: mostly tiny so records stay short, sometimes up to 'top'.
  function automatic int pick_len(input int top);
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
    return $urandom_range(0, top);
  endfunction

  task automatic push_byte(input logic [7:0] value, input logic last);
    byte_req_t req;
    req.value = value;
    req.last = last;
    message_q.push_back(req);
  endtask

  // Header as the flags say (short or 4-byte big endian payload length, optional
  // id length), then random content. Callers keep ilen 0 without IL.
  task automatic add_record(input logic [7:0] flags, input int tl, input int il,
                            input int pl);
    int i;
    push_byte(flags, 1'b0);
    push_byte(tl[7:0], 1'b0);
    if ((flags & FLAG_SR) != 8'd0) push_byte(pl[7:0], 1'b0);
    else for (i = 3; i >= 0; i--) push_byte(pl[8*i +: 8], 1'b0);
    if ((flags & FLAG_IL) != 8'd0) push_byte(il[7:0], 1'b0);
    for (i = 0; i < tl + il + pl; i++) push_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Well-formed record with random shape. Continuations use format 6 with no type
  // or id; format 6 outside a chunk is legal but must not carry a type or id either.
  task automatic add_random_record(input logic [7:0] marks);
    logic [7:0] flags;
    logic [2:0] tnf;
    int         tl, il, pl;
    flags = marks;
    if ($urandom_range(0, 3) == 0) flags = flags | FLAG_CF;
    if ($urandom_range(0, 3) != 0) flags = flags | FLAG_SR;
    pl = pick_len(40);
    tl = 0;
    il = 0;
    tnf = chunk_open ? TNF_UNCHANGED : 3'($urandom_range(0, 7));
    flags = flags | {5'd0, tnf};
    if (tnf != TNF_UNCHANGED) begin
      tl = pick_len(8);
      if ($urandom_range(0, 1) == 1) begin
        flags = flags | FLAG_IL;
        il = pick_len(6);
      end
    end
    add_record(flags, tl, il, pl);
    chunk_open = (flags & FLAG_CF) != 8'd0;
  endtask

  task automatic build_message();
    int         kind, first, cut;
    logic [2:0] tnf;
    chunk_open = 1'b0;
    // rarely the message opens without the begin flag and nothing else is parsed
    if ($urandom_range(0, 29) == 0)
      push_byte(8'($urandom_range(0, 255)) & ~FLAG_MB, 1'b0);

    // directed opening: short length with id, format 6 outside a chunk as an
    // empty long-form record, a two-chunk record, and an id-only record
    add_record(FLAG_MB | FLAG_SR | FLAG_IL | 8'd1, 1, 1, 2);
    add_record({5'd0, TNF_UNCHANGED}, 0, 0, 0);
    add_record(FLAG_CF | FLAG_SR | 8'd2, 1, 0, 1);
    add_record(FLAG_SR | {5'd0, TNF_UNCHANGED}, 0, 0, 2);
    add_record(FLAG_SR | FLAG_IL | 8'd7, 0, 3, 0);

    while (message_q.size() < BODY_BYTES) add_random_record(8'd0);

    // one way to end the message per run, picked by the seed
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2: begin
        if (chunk_open)
          add_record(FLAG_ME | FLAG_SR | {5'd0, TNF_UNCHANGED}, 0, 0, pick_len(8));
        else
          add_record(FLAG_ME | FLAG_SR | 8'd1, 1, 0, pick_len(8));
        message_q[message_q.size() - 1].last = 1'($urandom_range(0, 1));
      end
      3: push_byte(FLAG_MB | 8'($urandom_range(0, 127)), 1'b0);
      4: begin
        // end flag on a chunk, then again on the continuation after it
        if (chunk_open) add_record(FLAG_CF | FLAG_ME | FLAG_SR | {5'd0, TNF_UNCHANGED},
                                   0, 0, 1);
        else add_record(FLAG_CF | FLAG_ME | FLAG_SR | 8'd2, 1, 0, 2);
        push_byte(FLAG_ME | FLAG_SR | {5'd0, TNF_UNCHANGED}, 1'b0);
      end
      5: begin
        if (!chunk_open) add_random_record(FLAG_CF);
        tnf = 3'($urandom_range(0, 6));
        if (tnf == TNF_UNCHANGED) tnf = 3'd7;
        push_byte(FLAG_SR | {5'd0, tnf}, 1'b0);
      end
      6: begin
        if (!chunk_open) add_random_record(FLAG_CF);
        if ($urandom_range(0, 1) == 1) begin
          push_byte(FLAG_SR | {5'd0, TNF_UNCHANGED}, 1'b0);
          push_byte(8'($urandom_range(1, 255)), 1'b0);
        end else begin
          add_record(FLAG_SR | FLAG_IL | {5'd0, TNF_UNCHANGED}, 0, pick_len(3), pick_len(3));
        end
      end
      7, 8: begin
        // input runs out somewhere inside a record
        first = message_q.size();
        add_random_record(8'd0);
        cut = $urandom_range(first, message_q.size() - 1);
        while (message_q.size() > cut + 1) void'(message_q.pop_back());
        message_q[cut].last = 1'b1;
      end
      default: begin
        // complete record, but the message never carried the end flag
        add_random_record(8'd0);
        message_q[message_q.size() - 1].last = 1'b1;
      end
    endcase

    // trailing bytes the parser has to ignore
    repeat ($urandom_range(10, 40))
      push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // Source: one request per plan entry, random gaps, calm stretches now and then.
  initial begin : source_side
    int gap;
    bit source_calm;
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = 8'd0;
    end_of_input = 1'b0;
    source_calm = 1'b0;
    accepted_reqs = 0;
    build_message();
    hold_mark = message_q.size() / 4;
    plan_ready = 1'b1;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (message_q[i]) begin
      if ($urandom_range(0, 63) == 0) source_calm = !source_calm;
      gap = pick_pause(source_calm);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid = 1'b1;
      data_byte = message_q[i].value;
      end_of_input = message_q[i].last;
      // hold the request until the block takes it
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      accepted_reqs++;
      @(negedge clk);
    end
    in_valid = 1'b0;

    // let the pipeline drain, then a short tail to catch stray results
    wait (pending_results == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("ndef_message_parser: match");
    end else begin
      $display("ndef_message_parser: mismatch");
    end
    $finish;
  end

  // Sink: random stalls, plus one long hold-off while the source keeps offering,
  // so both registers fill and in_ready has to drop.
  initial begin : sink_side
    int  stall;
    bit  sink_calm;
    out_ready = 1'b0;
    long_hold_done = 1'b0;
    sink_calm = 1'b0;
    wait (plan_ready && !rst);
    @(negedge clk);
    forever begin
      if (!long_hold_done && accepted_reqs >= hold_mark) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold_done = 1'b1;
      end
      if ($urandom_range(0, 31) == 0) sink_calm = !sink_calm;
      out_ready = 1'b1;
      repeat (1 + pick_pause(1'b0)) @(negedge clk);
      stall = pick_pause(sink_calm);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // Hard stop in case the block hangs or drops results.
  initial begin : watchdog
    #2_000_000;
    $display("ndef_message_parser: mismatch");
    $finish;
  end

endmodule
